@@ rtl/lgw_pkg.sv @@
// Shared constants and types for the LCD window GRAM writer.
`timescale 1ns / 1ps

package lgw_pkg;

  // Panel geometry defaults.
  localparam int PANEL_WIDTH_DEF  = 240;
  localparam int PANEL_HEIGHT_DEF = 320;

  // Command codes on the display link.
  localparam logic [7:0] CMD_MADCTL   = 8'h36;
  localparam logic [7:0] CMD_COLSET   = 8'h2A;
  localparam logic [7:0] CMD_PAGESET  = 8'h2B;
  localparam logic [7:0] CMD_MEMWRITE = 8'h2C;

  // Bit positions in the access-control (orientation) byte.
  localparam int ORIENT_EXCHANGE = 5;
  localparam int ORIENT_MIRROR_A = 6;
  localparam int ORIENT_MIRROR_B = 7;

  // Address window after reset.
  localparam logic [15:0] COL_END_RESET = 16'd127;
  localparam logic [15:0] ROW_END_RESET = 16'd7;

  // Placed pixel position and whether it lies on the panel.
  typedef struct packed {
    logic       in_panel;
    logic [7:0] x;
    logic [8:0] y;
  } lgw_pos_t;

endpackage

@@ rtl/lgw_if.sv @@
// Handshake interfaces for the link byte and pixel channels.
`timescale 1ns / 1ps

interface lgw_byte_if;
  logic       valid;
  logic       ready;
  logic       is_command;
  logic [7:0] byte_value;

  modport source (output valid, output is_command, output byte_value, input ready);
  modport sink (input valid, input is_command, input byte_value, output ready);
endinterface

interface lgw_pixel_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_x;
  logic [8:0]  pixel_y;
  logic [15:0] pixel_color;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input pixel_color,
                output ready);
endinterface

@@ rtl/lgw_pixel_map.sv @@
// Orientation mirroring and panel clipping of the write cursor.
`timescale 1ns / 1ps

module lgw_pixel_map
  import lgw_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  logic [15:0] cursor_col,
  input  logic [15:0] cursor_row,
  input  logic [7:0]  orientation,
  output lgw_pos_t    pos
);

  localparam logic [15:0] WIDTH_LIM  = 16'(PANEL_WIDTH);
  localparam logic [15:0] HEIGHT_LIM = 16'(PANEL_HEIGHT);
  localparam logic [15:0] X_LAST     = 16'(PANEL_WIDTH - 1);
  localparam logic [15:0] Y_LAST     = 16'(PANEL_HEIGHT - 1);

  logic        exch;
  logic        mx;
  logic        my;
  logic [15:0] x_flip;
  logic [15:0] y_flip;

  assign exch   = orientation[ORIENT_EXCHANGE];
  assign mx     = exch ? orientation[ORIENT_MIRROR_A] : orientation[ORIENT_MIRROR_B];
  assign my     = exch ? orientation[ORIENT_MIRROR_B] : orientation[ORIENT_MIRROR_A];
  assign x_flip = X_LAST - cursor_col;
  assign y_flip = Y_LAST - cursor_row;

  // Either way round, the mirrored position is on the panel exactly when the
  // raw cursor is below the panel size.
  assign pos.in_panel = (cursor_col < WIDTH_LIM) && (cursor_row < HEIGHT_LIM);
  assign pos.x        = mx ? cursor_col[7:0] : x_flip[7:0];
  assign pos.y        = my ? y_flip[8:0] : cursor_row[8:0];

endmodule

@@ rtl/lcd_window_gram_writer.sv @@
// Top level of the LCD window GRAM writer: command decode, window, cursor and output.
`timescale 1ns / 1ps
//
// Takes bytes from a display link on the link channel, each flagged as a
// command or a data byte, and emits placed pixels on the pixel channel.
// Access control sets the orientation; column and page set load the address
// window, two big-endian 16-bit arguments each, swapped when row/column
// exchange is set. After memory write, each pair of data bytes forms an
// RGB565 colour that is mirrored, clipped to the panel and emitted; the
// cursor then steps through the window with wrap.
// Every item is handled in the cycle it is accepted, and a pixel appears on
// the pixel channel in the cycle after its second byte is accepted. One byte
// is taken per cycle while the link is not stalled by a waiting pixel.
// When the receiver stalls with a pixel waiting, the held pixel stays put and
// the link is stalled as well, for every byte, until that pixel is taken.
// Reset empties the output register, clears the orientation, sets the window
// to columns 0..127 and rows 0..7 and leaves nothing pending.

module lcd_window_gram_writer
  import lgw_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  lgw_byte_if.sink           link,
  lgw_pixel_if.source        pixel
);

  localparam logic [1:0] PEND_NONE    = 2'd0;
  localparam logic [1:0] PEND_MADCTL  = 2'd1;
  localparam logic [1:0] PEND_COLSET  = 2'd2;
  localparam logic [1:0] PEND_PAGESET = 2'd3;

  localparam logic [1:0] ARG_START_HI = 2'd0;
  localparam logic [1:0] ARG_START_LO = 2'd1;
  localparam logic [1:0] ARG_END_HI   = 2'd2;
  localparam logic [1:0] ARG_END_LO   = 2'd3;

  logic [7:0]  orientation, orientation_next;
  logic [15:0] col_start, col_start_next;
  logic [15:0] col_end, col_end_next;
  logic [15:0] row_start, row_start_next;
  logic [15:0] row_end, row_end_next;
  logic [15:0] cursor_col, cursor_col_next;
  logic [15:0] cursor_row, cursor_row_next;
  logic [1:0]  pending, pending_next;
  logic [1:0]  arg_count, arg_count_next;
  logic        writing, writing_next;
  logic        awaiting_low, awaiting_low_next;
  logic [7:0]  held_high, held_high_next;

  logic        out_valid;
  logic [7:0]  out_x;
  logic [8:0]  out_y;
  logic [15:0] out_color;

  logic        accept;
  logic        emit;
  logic        exch;
  logic        to_cols;
  logic [7:0]  b;
  logic [16:0] col_inc;
  logic [16:0] row_inc;
  logic        col_wrap;
  logic        row_wrap;
  logic [15:0] col_adv;
  logic [15:0] row_adv;
  lgw_pos_t    pos;

  lgw_pixel_map #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_map (
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .orientation(orientation),
    .pos        (pos)
  );

  assign link.ready = !out_valid || pixel.ready;
  assign accept     = link.valid && link.ready;
  assign b          = link.byte_value;
  assign exch       = orientation[ORIENT_EXCHANGE];
  assign to_cols    = (pending == PEND_COLSET) != exch;

  // Cursor steps; the sum is one bit wider so that 0xFFFF wraps too.
  assign col_inc  = {1'b0, cursor_col} + 17'd1;
  assign row_inc  = {1'b0, cursor_row} + 17'd1;
  assign col_wrap = col_inc > {1'b0, col_end};
  assign row_wrap = row_inc > {1'b0, row_end};
  assign col_adv  = col_wrap ? col_start : col_inc[15:0];
  assign row_adv  = row_wrap ? row_start : row_inc[15:0];

  always_comb begin
    orientation_next  = orientation;
    col_start_next    = col_start;
    col_end_next      = col_end;
    row_start_next    = row_start;
    row_end_next      = row_end;
    cursor_col_next   = cursor_col;
    cursor_row_next   = cursor_row;
    pending_next      = pending;
    arg_count_next    = arg_count;
    writing_next      = writing;
    awaiting_low_next = awaiting_low;
    held_high_next    = held_high;
    emit              = 1'b0;

    if (accept) begin
      if (link.is_command) begin
        writing_next      = 1'b0;
        awaiting_low_next = 1'b0;
        arg_count_next    = ARG_START_HI;
        pending_next      = PEND_NONE;
        case (b)
          CMD_MADCTL:   pending_next = PEND_MADCTL;
          CMD_COLSET:   pending_next = PEND_COLSET;
          CMD_PAGESET:  pending_next = PEND_PAGESET;
          CMD_MEMWRITE: writing_next = 1'b1;
          default:      pending_next = PEND_NONE;
        endcase
      end else if (pending == PEND_MADCTL) begin
        orientation_next = b;
        pending_next     = PEND_NONE;
      end else if (pending inside {PEND_COLSET, PEND_PAGESET}) begin
        // The start bytes load the cursor as well as the window start.
        case (arg_count)
          ARG_START_HI: begin
            if (to_cols) begin
              col_start_next  = {8'd0, b};
              cursor_col_next = {8'd0, b};
            end else begin
              row_start_next  = {8'd0, b};
              cursor_row_next = {8'd0, b};
            end
          end
          ARG_START_LO: begin
            if (to_cols) begin
              col_start_next  = {col_start[7:0], b};
              cursor_col_next = {cursor_col[7:0], b};
            end else begin
              row_start_next  = {row_start[7:0], b};
              cursor_row_next = {cursor_row[7:0], b};
            end
          end
          ARG_END_HI: begin
            if (to_cols) col_end_next = {8'd0, b};
            else         row_end_next = {8'd0, b};
          end
          default: begin
            if (to_cols) col_end_next = {col_end[7:0], b};
            else         row_end_next = {row_end[7:0], b};
          end
        endcase
        if (arg_count == ARG_END_LO) begin
          arg_count_next = ARG_START_HI;
          pending_next   = PEND_NONE;
        end else begin
          arg_count_next = arg_count + 2'd1;
        end
      end else if (writing) begin
        if (!awaiting_low) begin
          held_high_next    = b;
          awaiting_low_next = 1'b1;
        end else begin
          awaiting_low_next = 1'b0;
          emit              = pos.in_panel;
          // Row-major normally, column-major when exchanged.
          if (exch) begin
            cursor_row_next = row_adv;
            if (row_wrap) cursor_col_next = col_adv;
          end else begin
            cursor_col_next = col_adv;
            if (col_wrap) cursor_row_next = row_adv;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation  <= 8'd0;
      col_start    <= 16'd0;
      col_end      <= COL_END_RESET;
      row_start    <= 16'd0;
      row_end      <= ROW_END_RESET;
      cursor_col   <= 16'd0;
      cursor_row   <= 16'd0;
      pending      <= PEND_NONE;
      arg_count    <= ARG_START_HI;
      writing      <= 1'b0;
      awaiting_low <= 1'b0;
      held_high    <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      orientation  <= orientation_next;
      col_start    <= col_start_next;
      col_end      <= col_end_next;
      row_start    <= row_start_next;
      row_end      <= row_end_next;
      cursor_col   <= cursor_col_next;
      cursor_row   <= cursor_row_next;
      pending      <= pending_next;
      arg_count    <= arg_count_next;
      writing      <= writing_next;
      awaiting_low <= awaiting_low_next;
      held_high    <= held_high_next;
      if (emit)             out_valid <= 1'b1;
      else if (pixel.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x     <= pos.x;
      out_y     <= pos.y;
      out_color <= {held_high, b};
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.pixel_x     = out_x;
  assign pixel.pixel_y     = out_y;
  assign pixel.pixel_color = out_color;

endmodule

@@ rtl/lgw_checker.sv @@
// Port-level assertions for the LCD window GRAM writer, bound to the top level.
`timescale 1ns / 1ps

module lgw_checker
  import lgw_pkg::*;
#(
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        link_valid,
  input logic        link_ready,
  input logic        link_is_command,
  input logic        pixel_valid,
  input logic        pixel_ready,
  input logic [8:0]  pixel_y,
  input logic [15:0] pixel_color
);

  localparam logic [9:0] HEIGHT_LIM = 10'(PANEL_HEIGHT);
  localparam bit         Y_CHECKED  = PANEL_HEIGHT <= 512;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel item shown after reset");

  // With nothing waiting at the output, the link is always served.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !pixel_valid |-> link_ready)
    else $error("link stalled with an empty output register");

  // A fresh pixel item follows an accepted data byte in the cycle before.
  a_pixel_cause: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !$past(pixel_valid && !pixel_ready))
      |-> $past(link_valid && link_ready && !link_is_command))
    else $error("pixel item without a data byte");

  // Clipping keeps emitted rows on the panel; checked for panels of up to 512 rows.
  a_row_on_panel: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (!Y_CHECKED || ({1'b0, pixel_y} < HEIGHT_LIM)))
    else $error("pixel row beyond the panel");

  // A stalled pixel item holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=> (pixel_valid && $stable(pixel_color)))
    else $error("stalled pixel item changed");

endmodule

bind lcd_window_gram_writer lgw_checker #(
  .PANEL_HEIGHT(PANEL_HEIGHT)
) u_lgw_checker (
  .clk            (clk),
  .rst            (rst),
  .link_valid     (link.valid),
  .link_ready     (link.ready),
  .link_is_command(link.is_command),
  .pixel_valid    (pixel.valid),
  .pixel_ready    (pixel.ready),
  .pixel_y        (pixel.pixel_y),
  .pixel_color    (pixel.pixel_color)
);
